FILE: src/btp_pkg.sv
// btp_pkg: shared codes, field widths and structs for the battery thermal
// protection block. No dependencies; every other file imports it.

package btp_pkg;

   localparam int CUR_W    = 12;
   localparam int MARGIN_W = 9;
   localparam int FAULT_W  = 3;
   localparam int OUTC_W   = 2;
   localparam int IDX_W    = 3;

   // fault codes
   localparam logic [FAULT_W-1:0] FC_NORMAL  = 3'd0;
   localparam logic [FAULT_W-1:0] FC_OVER    = 3'd1;
   localparam logic [FAULT_W-1:0] FC_CHG_INH = 3'd2;
   localparam logic [FAULT_W-1:0] FC_DIS_INH = 3'd3;
   localparam logic [FAULT_W-1:0] FC_DIS_LIM = 3'd4;

   // manual reset outcome codes
   localparam logic [OUTC_W-1:0] RO_NONE   = 2'd0;
   localparam logic [OUTC_W-1:0] RO_ACCEPT = 2'd1;
   localparam logic [OUTC_W-1:0] RO_DENY   = 2'd2;

   // transaction modes
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_RESET  = 1'b1;

   // register indexes
   localparam logic [IDX_W-1:0] REG_MAX_TEMP      = 3'd0;
   localparam logic [IDX_W-1:0] REG_MIN_CHG_TEMP  = 3'd1;
   localparam logic [IDX_W-1:0] REG_MIN_DIS_TEMP  = 3'd2;
   localparam logic [IDX_W-1:0] REG_MIN_FULL_TEMP = 3'd3;
   localparam logic [IDX_W-1:0] REG_RESET_MARGIN  = 3'd4;
   localparam logic [IDX_W-1:0] REG_LIMITED_CUR   = 3'd5;
   localparam logic [IDX_W-1:0] REG_FULL_CUR      = 3'd6;

   localparam logic [MARGIN_W-1:0] RESET_MARGIN_DEF = 9'd50;
   localparam logic [CUR_W-1:0]    LIMITED_CUR_DEF  = 12'd100;
   localparam logic [CUR_W-1:0]    FULL_CUR_DEF     = 12'd1000;
   localparam logic [CUR_W-1:0]    CAP_RESET        = 12'd1000;

   typedef struct packed {
      logic [MARGIN_W-1:0] reset_margin;
      logic [CUR_W-1:0]    limited_current;
      logic [CUR_W-1:0]    full_current;
   } cur_cfg_type;

   typedef struct packed {
      logic [FAULT_W-1:0] fault;
      logic               chg_blk;
      logic               dis_blk;
      logic [CUR_W-1:0]   cap;
      logic               rst_need;
      logic               cont_open;
      logic               cool;
   } prot_state_type;

   typedef struct packed {
      logic [FAULT_W-1:0] fault_code;
      logic               charge_allowed;
      logic               discharge_allowed;
      logic [CUR_W-1:0]   allowed_current;
      logic               contactors_opened;
      logic               cooling_on;
      logic               reset_pending;
      logic [OUTC_W-1:0]  reset_outcome;
   } rsp_data_type;

endpackage

FILE: src/btp_if.sv
// btp_req_if / btp_rsp_if: valid-ready channels of the thermal protection block.
// Depends on btp_pkg for field widths.

interface btp_req_if
   import btp_pkg::*;
#(
   parameter int TEMP_BITS = 12
);
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic signed [TEMP_BITS-1:0] temperature;

   modport source (output valid, output mode, output temperature, input ready);
   modport sink   (input valid, input mode, input temperature, output ready);
endinterface

interface btp_rsp_if
   import btp_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [FAULT_W-1:0] fault_code;
   logic               charge_allowed;
   logic               discharge_allowed;
   logic [CUR_W-1:0]   allowed_current;
   logic               contactors_opened;
   logic               cooling_on;
   logic               reset_pending;
   logic [OUTC_W-1:0]  reset_outcome;

   modport source (output valid, output fault_code, output charge_allowed,
                   output discharge_allowed, output allowed_current,
                   output contactors_opened, output cooling_on,
                   output reset_pending, output reset_outcome, input ready);
   modport sink   (input valid, input fault_code, input charge_allowed,
                   input discharge_allowed, input allowed_current,
                   input contactors_opened, input cooling_on,
                   input reset_pending, input reset_outcome, output ready);
endinterface

FILE: src/btp_csr.sv
// btp_csr: configuration registers of the thermal protection block.
// Depends on btp_pkg for register indexes, defaults and the current config struct.

module btp_csr
   import btp_pkg::*;
#(
   parameter int TEMP_BITS = 12,
   parameter int TW        = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [TW-1:0]        csr_wdata,
   output logic signed [TW-1:0] max_temp,
   output logic signed [TW-1:0] min_chg_temp,
   output logic signed [TW-1:0] min_dis_temp,
   output logic signed [TW-1:0] min_full_temp,
   output cur_cfg_type          cur_cfg
);

   logic signed [TW-1:0] max_temp_ff, min_chg_ff, min_dis_ff, min_full_ff;
   cur_cfg_type          cur_cfg_ff;
   logic signed [TW-1:0] wr_temp;

   // thresholds are sign-extended from the sample width
   assign wr_temp = TW'(signed'(csr_wdata[TEMP_BITS-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         max_temp_ff                <= TW'(600);
         min_chg_ff                 <= TW'(0);
         min_dis_ff                 <= TW'(-200);
         min_full_ff                <= TW'(-100);
         cur_cfg_ff.reset_margin    <= RESET_MARGIN_DEF;
         cur_cfg_ff.limited_current <= LIMITED_CUR_DEF;
         cur_cfg_ff.full_current    <= FULL_CUR_DEF;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAX_TEMP:      max_temp_ff <= wr_temp;
            REG_MIN_CHG_TEMP:  min_chg_ff  <= wr_temp;
            REG_MIN_DIS_TEMP:  min_dis_ff  <= wr_temp;
            REG_MIN_FULL_TEMP: min_full_ff <= wr_temp;
            REG_RESET_MARGIN:  cur_cfg_ff.reset_margin    <= csr_wdata[MARGIN_W-1:0];
            REG_LIMITED_CUR:   cur_cfg_ff.limited_current <= csr_wdata[CUR_W-1:0];
            REG_FULL_CUR:      cur_cfg_ff.full_current    <= csr_wdata[CUR_W-1:0];
            default: ;
         endcase
      end
   end

   assign max_temp      = max_temp_ff;
   assign min_chg_temp  = min_chg_ff;
   assign min_dis_temp  = min_dis_ff;
   assign min_full_temp = min_full_ff;
   assign cur_cfg       = cur_cfg_ff;

endmodule

FILE: src/btp_eval.sv
// btp_eval: combinational update of the protection state for one transaction
// and the result fields it produces. Depends on btp_pkg.

module btp_eval
   import btp_pkg::*;
#(
   parameter int TEMP_BITS = 12,
   parameter int TW        = 12
) (
   input  logic                        mode,
   input  logic signed [TEMP_BITS-1:0] temperature,
   input  prot_state_type              state_cur,
   input  logic signed [TW-1:0]        held_cur,
   input  logic signed [TW-1:0]        max_temp,
   input  logic signed [TW-1:0]        min_chg_temp,
   input  logic signed [TW-1:0]        min_dis_temp,
   input  logic signed [TW-1:0]        min_full_temp,
   input  cur_cfg_type                 cur_cfg,
   output prot_state_type              state_nxt,
   output logic signed [TW-1:0]        held_nxt,
   output rsp_data_type                result
);

   function automatic prot_state_type go_normal(prot_state_type s, logic [CUR_W-1:0] full);
      prot_state_type r;
      r = s;
      if (!r.rst_need) begin
         r.fault   = FC_NORMAL;
         r.chg_blk = 1'b0;
         r.dis_blk = 1'b0;
         r.cap     = full;
      end
      return r;
   endfunction

   function automatic prot_state_type go_over(prot_state_type s);
      prot_state_type r;
      r = s;
      if (r.fault != FC_OVER) begin
         r.fault     = FC_OVER;
         r.cont_open = 1'b1;
         r.cool      = 1'b1;
         r.chg_blk   = 1'b1;
         r.dis_blk   = 1'b1;
         r.cap       = '0;
         r.rst_need  = 1'b1;
      end
      return r;
   endfunction

   function automatic prot_state_type go_cold(prot_state_type s, logic signed [TW-1:0] t,
                                              logic signed [TW-1:0] mct,
                                              logic signed [TW-1:0] mdt,
                                              logic signed [TW-1:0] mft,
                                              logic [CUR_W-1:0] lim);
      prot_state_type r;
      r = s;
      if (t < mct && !r.chg_blk) begin
         r.fault   = FC_CHG_INH;
         r.chg_blk = 1'b1;
      end
      priority if (t < mdt) begin
         if (!r.dis_blk || r.fault != FC_DIS_INH) begin
            r.fault   = FC_DIS_INH;
            r.dis_blk = 1'b1;
            r.cap     = '0;
         end
      end else if (t < mft) begin
         // an active discharge inhibit is only cleared from the normal band
         if (r.fault != FC_DIS_LIM && r.fault != FC_DIS_INH) begin
            r.fault   = FC_DIS_LIM;
            r.cap     = lim;
            r.dis_blk = 1'b0;
         end
      end else begin
      end
      return r;
   endfunction

   function automatic prot_state_type do_sample(prot_state_type s, logic signed [TW-1:0] t,
                                                logic signed [TW-1:0] mxt,
                                                logic signed [TW-1:0] mct,
                                                logic signed [TW-1:0] mdt,
                                                logic signed [TW-1:0] mft,
                                                cur_cfg_type cc);
      prot_state_type r;
      r = s;
      priority if (t > mxt) begin
         r = go_over(s);
      end else if (t < mct || t < mft) begin
         if (s.fault != FC_OVER) r = go_cold(s, t, mct, mdt, mft, cc.limited_current);
      end else if (s.fault != FC_OVER || !s.rst_need) begin
         r = go_normal(s, cc.full_current);
      end else begin
      end
      return r;
   endfunction

   logic signed [TW-1:0]   t_in;
   logic signed [TW+1:0]   reset_lim;
   logic signed [TW+1:0]   held_ext;
   prot_state_type         cleared;
   prot_state_type         st;
   logic [OUTC_W-1:0]      outcome;

   assign t_in      = TW'(temperature);
   assign reset_lim = (TW+2)'(max_temp) - $signed((TW+2)'(cur_cfg.reset_margin));
   assign held_ext  = (TW+2)'(held_cur);

   always_comb begin
      cleared           = state_cur;
      cleared.rst_need  = 1'b0;
      cleared.cont_open = 1'b0;
      st                = state_cur;
      held_nxt          = held_cur;
      outcome           = RO_NONE;
      priority if (mode == MODE_SAMPLE) begin
         held_nxt = t_in;
         st = do_sample(state_cur, t_in, max_temp, min_chg_temp, min_dis_temp,
                        min_full_temp, cur_cfg);
      end else if (state_cur.fault == FC_OVER) begin
         if (held_ext <= reset_lim) begin
            // clear the latch, then re-run the held sample
            st = do_sample(go_normal(cleared, cur_cfg.full_current), held_cur, max_temp,
                           min_chg_temp, min_dis_temp, min_full_temp, cur_cfg);
            outcome = RO_ACCEPT;
         end else begin
            outcome = RO_DENY;
         end
      end else begin
      end
   end

   assign state_nxt = st;

   always_comb begin
      result.fault_code        = st.fault;
      result.charge_allowed    = st.fault != FC_OVER && held_nxt >= min_chg_temp && !st.chg_blk;
      result.discharge_allowed = st.fault != FC_OVER && held_nxt >= min_dis_temp && !st.dis_blk;
      priority if (st.fault == FC_OVER || st.dis_blk || held_nxt < min_dis_temp)
         result.allowed_current = '0;
      else if (st.fault == FC_DIS_LIM || held_nxt < min_full_temp)
         result.allowed_current = st.cap;
      else
         result.allowed_current = cur_cfg.full_current;
      result.contactors_opened = st.cont_open;
      result.cooling_on        = st.cool;
      result.reset_pending     = st.rst_need;
      result.reset_outcome     = outcome;
   end

endmodule

FILE: src/battery_thermal_protection_fsm_unit.sv
// battery_thermal_protection_fsm_unit: top level of the thermal protection block.
// Depends on btp_pkg, btp_if, btp_csr and btp_eval.
//
//   channel   direction  handshake      payload
//   req_if    in         valid/ready    mode, temperature
//   rsp_if    out        valid/ready    fault_code .. reset_outcome
//   csr_*     in         write enable   csr_index, csr_wdata
//
// each transaction is registered at the input, evaluated combinationally against
// the protection state and lands in the result register; one transaction per cycle
// is sustained while results are taken, set by the single state update per cycle.
// reset is synchronous; it restores the register defaults and the state.
// a stalled result holds the result register; the input register still takes a
// transaction whenever the one ahead of it can move.

module battery_thermal_protection_fsm_unit
   import btp_pkg::*;
#(
   parameter int TEMP_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   btp_req_if.sink                           req_if,
   btp_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [IDX_W-1:0]                  csr_index,
   input  logic [(TEMP_BITS > 12 ? TEMP_BITS : 12)-1:0] csr_wdata
);

   localparam int TW = (TEMP_BITS > 12) ? TEMP_BITS : 12;

   logic signed [TW-1:0] max_temp, min_chg_temp, min_dis_temp, min_full_temp;
   cur_cfg_type          cur_cfg;

   logic                        s1_valid_ff;
   logic                        s1_mode_ff;
   logic signed [TEMP_BITS-1:0] s1_temp_ff;
   logic                        s2_valid_ff;
   rsp_data_type                s2_data_ff;

   prot_state_type       state_ff, state_in;
   logic signed [TW-1:0] held_ff, held_in;
   rsp_data_type         result;

   logic advance;
   logic req_take;

   btp_csr #(.TEMP_BITS(TEMP_BITS), .TW(TW)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .max_temp      (max_temp),
      .min_chg_temp  (min_chg_temp),
      .min_dis_temp  (min_dis_temp),
      .min_full_temp (min_full_temp),
      .cur_cfg       (cur_cfg)
   );

   btp_eval #(.TEMP_BITS(TEMP_BITS), .TW(TW)) u_eval (
      .mode          (s1_mode_ff),
      .temperature   (s1_temp_ff),
      .state_cur     (state_ff),
      .held_cur      (held_ff),
      .max_temp      (max_temp),
      .min_chg_temp  (min_chg_temp),
      .min_dis_temp  (min_dis_temp),
      .min_full_temp (min_full_temp),
      .cur_cfg       (cur_cfg),
      .state_nxt     (state_in),
      .held_nxt      (held_in),
      .result        (result)
   );

   assign advance      = s1_valid_ff && (!s2_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_if.mode;
         s1_temp_ff <= req_if.temperature;
      end
   end

   // protection state moves only when a transaction leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fault     <= FC_NORMAL;
         state_ff.chg_blk   <= 1'b0;
         state_ff.dis_blk   <= 1'b0;
         state_ff.cap       <= CAP_RESET;
         state_ff.rst_need  <= 1'b0;
         state_ff.cont_open <= 1'b0;
         state_ff.cool      <= 1'b0;
         held_ff            <= TW'(250);
      end else if (advance) begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) s2_data_ff <= result;
   end

   assign rsp_if.valid             = s2_valid_ff;
   assign rsp_if.fault_code        = s2_data_ff.fault_code;
   assign rsp_if.charge_allowed    = s2_data_ff.charge_allowed;
   assign rsp_if.discharge_allowed = s2_data_ff.discharge_allowed;
   assign rsp_if.allowed_current   = s2_data_ff.allowed_current;
   assign rsp_if.contactors_opened = s2_data_ff.contactors_opened;
   assign rsp_if.cooling_on        = s2_data_ff.cooling_on;
   assign rsp_if.reset_pending     = s2_data_ff.reset_pending;
   assign rsp_if.reset_outcome     = s2_data_ff.reset_outcome;

endmodule

FILE: src/btp_checker.sv
// btp_checker: port-level assertions for the thermal protection block, and the
// bind that attaches them to the top level. Depends on btp_pkg.

module btp_checker
   import btp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FAULT_W-1:0] fault_code,
   input logic               charge_allowed,
   input logic               discharge_allowed,
   input logic [CUR_W-1:0]   allowed_current,
   input logic               contactors_opened,
   input logic               cooling_on,
   input logic               reset_pending,
   input logic [OUTC_W-1:0]  reset_outcome
);

   logic seen_cool_ff;

   // cooling, once reported, stays on until reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_cool_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && cooling_on) begin
         seen_cool_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

   a_cool_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_cool_ff |-> cooling_on)
      else $error("cooling cleared without reset");

   a_over_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault_code == FC_OVER |->
         contactors_opened && reset_pending && allowed_current == '0 &&
         !charge_allowed && !discharge_allowed)
      else $error("critical fault without safe outputs");

   a_reset_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && reset_outcome == RO_ACCEPT |->
         !contactors_opened && !reset_pending && fault_code != FC_OVER)
      else $error("accepted reset left the latch set");

endmodule

bind battery_thermal_protection_fsm_unit btp_checker u_btp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .fault_code        (rsp_if.fault_code),
   .charge_allowed    (rsp_if.charge_allowed),
   .discharge_allowed (rsp_if.discharge_allowed),
   .allowed_current   (rsp_if.allowed_current),
   .contactors_opened (rsp_if.contactors_opened),
   .cooling_on        (rsp_if.cooling_on),
   .reset_pending     (rsp_if.reset_pending),
   .reset_outcome     (rsp_if.reset_outcome)
);
